// File: rtl/core/assert_macros.svh
// assertion helpers shared by the finder modules
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sflf_pkg.sv
// shared types and constants for the substring first/last finder
// no dependencies
package sflf_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W = 5;
  localparam int IDX_W = 17;
  localparam int CFG_W = 64;
  localparam int PAT_BYTES = 16;
  localparam int SEL_W = 4;
  localparam int PATTERN_MAX_DEF = 16;
  localparam longint unsigned TEXT_MAX_DEF = 65536;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PAT_LOW     = 2'd0,
    CFG_PAT_HIGH    = 2'd1,
    CFG_PAT_LEN     = 2'd2,
    CFG_SEARCH_LAST = 2'd3
  } cfg_reg_t;

  typedef logic [PAT_BYTES-1:0][DATA_W-1:0] pat_t;

  // one accepted text beat as seen by the tracker
  typedef struct packed {
    logic accept;
    logic last;
  } step_t;

  // result handed to the output buffer
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

// File: rtl/core/sflf_cell.sv
// one window cell: holds one text byte and compares the incoming byte
// with the pattern byte that lines up with this position; uses sflf_pkg
module sflf_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [sflf_pkg::DATA_W-1:0] byte_in,
  input  sflf_pkg::pat_t              pattern,
  input  logic [sflf_pkg::LEN_W-1:0]  pattern_length,
  output logic [sflf_pkg::DATA_W-1:0] byte_q,
  output logic                        hit
);

  logic [sflf_pkg::LEN_W-1:0] back_pos;
  logic [sflf_pkg::SEL_W-1:0] sel;
  logic                       active;

  // pattern position that meets this window slot: length - 1 - slot
  assign back_pos = pattern_length - sflf_pkg::LEN_W'(1) - sflf_pkg::LEN_W'(IDX);
  assign sel      = back_pos[sflf_pkg::SEL_W-1:0];
  assign active   = sflf_pkg::LEN_W'(IDX) < pattern_length;

  // slots past the pattern length do not take part
  assign hit = !active || (byte_in == pattern[sel]);

  // byte moves on to the older neighbor
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

endmodule

// File: rtl/core/sflf_tracker.sv
// byte counter and first/last match tracking for the finder
// uses sflf_pkg and assert_macros.svh
`include "assert_macros.svh"

module sflf_tracker #(
  parameter int              PATTERN_MAX = sflf_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = sflf_pkg::TEXT_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sflf_pkg::step_t            step,
  input  logic                       hit_all,
  input  logic [sflf_pkg::LEN_W-1:0] pattern_length,
  input  logic                       search_last,
  output logic                       shift_en,
  output sflf_pkg::res_t             res
);

  localparam int CNT_W  = $clog2(TEXT_MAX + 1);
  localparam int WIDE_W = (CNT_W > sflf_pkg::IDX_W) ? CNT_W : sflf_pkg::IDX_W;

  logic [CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [CNT_W-1:0] first_idx, first_idx_next;
  logic [CNT_W-1:0] last_idx, last_idx_next;
  logic             first_valid, first_valid_next;
  logic             last_valid, last_valid_next;

  logic [CNT_W-1:0] seen_inc;
  logic [CNT_W-1:0] len_ext;
  logic [CNT_W-1:0] start;
  logic [CNT_W-1:0] sel_idx;
  logic [WIDE_W-1:0] sel_wide;
  logic             live;
  logic             len_ok;
  logic             match;

  // counting stops at the text limit, later bytes are ignored
  assign live     = step.accept && (bytes_seen != CNT_W'(TEXT_MAX));
  assign shift_en = live;
  assign seen_inc = bytes_seen + CNT_W'(1);
  assign len_ext  = CNT_W'(pattern_length);
  assign len_ok   = (pattern_length != '0) &&
                    (pattern_length <= sflf_pkg::LEN_W'(PATTERN_MAX));
  assign match    = live && len_ok && (seen_inc >= len_ext) && hit_all;
  assign start    = seen_inc - len_ext;

  // updated tracking values including the current beat
  always_comb begin
    bytes_seen_next  = live ? seen_inc : bytes_seen;
    first_valid_next = first_valid || match;
    first_idx_next   = first_valid ? first_idx : (match ? start : first_idx);
    last_valid_next  = last_valid || match;
    last_idx_next    = match ? start : last_idx;
  end

  // result as seen at the final beat
  always_comb begin
    res.found = 1'b0;
    sel_idx   = '0;
    if (pattern_length == '0) begin
      res.found = 1'b1;
      sel_idx   = search_last ? bytes_seen_next : '0;
    end else if (search_last) begin
      res.found = last_valid_next;
      sel_idx   = last_valid_next ? last_idx_next : '0;
    end else begin
      res.found = first_valid_next;
      sel_idx   = first_valid_next ? first_idx_next : '0;
    end
    sel_wide  = WIDE_W'(sel_idx);
    res.index = sel_wide[sflf_pkg::IDX_W-1:0];
  end

  // tracking state, cleared after each final beat
  always_ff @(posedge clk) begin
    if (rst || (step.accept && step.last)) begin
      bytes_seen  <= '0;
      first_idx   <= '0;
      first_valid <= 1'b0;
      last_idx    <= '0;
      last_valid  <= 1'b0;
    end else if (step.accept) begin
      bytes_seen  <= bytes_seen_next;
      first_idx   <= first_idx_next;
      first_valid <= first_valid_next;
      last_idx    <= last_idx_next;
      last_valid  <= last_valid_next;
    end
  end

  `SFLF_ASSERT_IMP(a_valid_pair, 1'b1, first_valid == last_valid, "first and last valid disagree")
  `SFLF_ASSERT_IMP(a_order, first_valid, first_idx <= last_idx, "first match after last match")
  `SFLF_ASSERT_IMP(a_count_cap, 1'b1, bytes_seen <= CNT_W'(TEXT_MAX), "byte count past text limit")

endmodule

// File: rtl/core/substring_first_last_finder.sv
// substring first/last finder top level: config registers, cell chain,
// tracker and output buffer; uses sflf_pkg, sflf_cell, sflf_tracker
//
// channel   dir  beat fields
// s_axis    in   tdata[7:0] text_byte, tlast final_byte
// m_axis    out  tdata[0] found, tdata[17:1] match_index, rest zero
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// one text byte per cycle while s_tready is high; the window compare over
// all cells is combinational; the final result goes to the output
// register, or the skid slot while that is held; the output register plus
// a skid slot hold two results; s_tready drops only while both are full
// rst is synchronous and clears tracking, buffer and config registers
`include "assert_macros.svh"

module substring_first_last_finder #(
  parameter int              PATTERN_MAX = sflf_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = sflf_pkg::TEXT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // final_byte
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] found, [17:1] match_index, [23:18] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [sflf_pkg::CFG_W-1:0] cfg_data
);

  localparam int RES_W = 1 + sflf_pkg::IDX_W;

  logic [sflf_pkg::CFG_W-1:0] pat_low, pat_high;
  logic [sflf_pkg::LEN_W-1:0] pattern_length;
  logic                       search_last;
  sflf_pkg::pat_t             pattern;

  sflf_pkg::step_t step;
  sflf_pkg::res_t  res;
  logic            shift_en;
  logic            push, pop;

  logic [sflf_pkg::DATA_W-1:0] chain_in [PATTERN_MAX];
  logic [sflf_pkg::DATA_W-1:0] chain_q  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]      cell_hit;

  logic           out_valid, skid_valid;
  sflf_pkg::res_t out_res, skid_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low        <= '0;
      pat_high       <= '0;
      pattern_length <= '0;
      search_last    <= 1'b0;
    end else if (cfg_we) begin
      unique case (sflf_pkg::cfg_reg_t'(cfg_index))
        sflf_pkg::CFG_PAT_LOW:     pat_low        <= cfg_data;
        sflf_pkg::CFG_PAT_HIGH:    pat_high       <= cfg_data;
        sflf_pkg::CFG_PAT_LEN:     pattern_length <= cfg_data[sflf_pkg::LEN_W-1:0];
        sflf_pkg::CFG_SEARCH_LAST: search_last    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pattern = {pat_high, pat_low};

  // input handshake
  assign s_tready    = !skid_valid;
  assign step.accept = s_tvalid && s_tready;
  assign step.last   = s_tlast;

  // window cells, slot 0 takes the newest byte
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign chain_in[k] = s_tdata;
    end else begin : g_link
      assign chain_in[k] = chain_q[k-1];
    end
    sflf_cell #(
      .IDX(k)
    ) u_cell (
      .clk            (clk),
      .shift_en       (shift_en),
      .byte_in        (chain_in[k]),
      .pattern        (pattern),
      .pattern_length (pattern_length),
      .byte_q         (chain_q[k]),
      .hit            (cell_hit[k])
    );
  end

  sflf_tracker #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .hit_all        (&cell_hit),
    .pattern_length (pattern_length),
    .search_last    (search_last),
    .shift_en       (shift_en),
    .res            (res)
  );

  // output register with skid slot
  assign push = step.accept && step.last;
  assign pop  = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= res;
      end else begin
        out_res  <= res;
      end
    end else if (push) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(24 - RES_W)'(0), out_res.index, out_res.found};

  `SFLF_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid slot full with empty output")
  `SFLF_ASSERT_NXT(a_skid_drains, pop && skid_valid && !push, !skid_valid && out_valid, "skid slot did not drain")
  `SFLF_ASSERT_NXT(a_push_lands, push && !out_valid, out_valid, "result lost on empty buffer")

endmodule
